// ----- design/lfms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfms_pkg
// Shared types, codes and constants for the line follower mode sequencer.
// ----------------------------------------------------------------------------
package lfms_pkg;

    // Fixed timeouts in milliseconds.
    localparam logic [31:0] CURVE_TIMEOUT_MS  = 32'd250;
    localparam logic [31:0] LOST_TIMEOUT_MS   = 32'd600;
    localparam logic [31:0] HWTEST_TIMEOUT_MS = 32'd3000;

    // Configuration reset values.
    localparam logic [15:0] FAN_DELAY_RESET    = 16'd300;
    localparam logic [31:0] FINISH_MIN_RESET   = 32'd1000;
    localparam logic [11:0] CRUISE_SPEED_RESET = 12'd500;

    // Bit positions of the latched requests.
    localparam int REQ_STOP   = 0;
    localparam int REQ_ARM    = 1;
    localparam int REQ_DISARM = 2;
    localparam int REQ_START  = 3;

    // Bit positions of the sticky fault flags.
    localparam int FLT_SENSOR = 0;
    localparam int FLT_CONFIG = 1;
    localparam int FLT_HWTO   = 2;

    // Item opcodes.
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_STOP      = 3'd1,
        OP_ARM       = 3'd2,
        OP_DISARM    = 3'd3,
        OP_START     = 3'd4,
        OP_HWTEST    = 3'd5,
        OP_CAL_BEGIN = 3'd6,
        OP_CAL_END   = 3'd7
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FAN_DELAY    = 2'd0,
        CFG_FINISH_MIN   = 2'd1,
        CFG_CRUISE_SPEED = 2'd2
    } t_cfg_idx;

    // Operating modes, one-hot.
    typedef enum logic [14:0] {
        MODE_BOOT      = 15'b000000000000001,
        MODE_SELF_TEST = 15'b000000000000010,
        MODE_IDLE      = 15'b000000000000100,
        MODE_CAL       = 15'b000000000001000,
        MODE_READY     = 15'b000000000010000,
        MODE_ARMED     = 15'b000000000100000,
        MODE_SPINUP    = 15'b000000001000000,
        MODE_RUNNING   = 15'b000000010000000,
        MODE_CROSSING  = 15'b000000100000000,
        MODE_CURVE     = 15'b000001000000000,
        MODE_LOST      = 15'b000010000000000,
        MODE_FINISH    = 15'b000100000000000,
        MODE_SAFE_STOP = 15'b001000000000000,
        MODE_HWTEST    = 15'b010000000000000,
        MODE_ERROR     = 15'b100000000000000
    } t_mode;

    // Reported mode numbers.
    localparam logic [3:0] CODE_BOOT      = 4'd0;
    localparam logic [3:0] CODE_SELF_TEST = 4'd1;
    localparam logic [3:0] CODE_IDLE      = 4'd2;
    localparam logic [3:0] CODE_CAL       = 4'd3;
    localparam logic [3:0] CODE_READY     = 4'd4;
    localparam logic [3:0] CODE_ARMED     = 4'd5;
    localparam logic [3:0] CODE_SPINUP    = 4'd6;
    localparam logic [3:0] CODE_RUNNING   = 4'd7;
    localparam logic [3:0] CODE_CROSSING  = 4'd8;
    localparam logic [3:0] CODE_CURVE     = 4'd9;
    localparam logic [3:0] CODE_LOST      = 4'd10;
    localparam logic [3:0] CODE_FINISH    = 4'd11;
    localparam logic [3:0] CODE_SAFE_STOP = 4'd12;
    localparam logic [3:0] CODE_HWTEST    = 4'd13;
    localparam logic [3:0] CODE_ERROR     = 4'd14;

    typedef enum logic [2:0] {
        MOTOR_HOLD  = 3'd0,
        MOTOR_BRAKE = 3'd1,
        MOTOR_COAST = 3'd2,
        MOTOR_PID   = 3'd3,
        MOTOR_SPIN  = 3'd4
    } t_motor_cmd;

    typedef enum logic [1:0] {
        FAN_HOLD = 2'd0,
        FAN_OFF  = 2'd1,
        FAN_RAMP = 2'd2,
        FAN_RUN  = 2'd3
    } t_fan_cmd;

    typedef struct packed {
        logic [15:0] fan_delay_ms;
        logic [31:0] finish_min_run_ms;
        logic [11:0] cruise_speed;
    } t_cfg;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] now_ms;
        logic        check_ok;
        logic        critical_fault;
        logic        crossing_seen;
        logic        loss_confirmed;
        logic        right_marker;
        logic        left_curve;
        logic        line_present;
        logic        line_missing;
        logic        error_negative;
    } t_item;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] enter_time;
        logic [31:0] run_start_time;
        logic [2:0]  fault;
        logic [3:0]  pending;
    } t_state;

    typedef struct packed {
        logic [3:0]         mode;
        t_motor_cmd         motor_cmd;
        t_fan_cmd           fan_cmd;
        logic               pid_clear;
        logic               hold_integral;
        logic signed [11:0] left_drive;
        logic signed [11:0] right_drive;
        logic [2:0]         fault_bits;
        logic               accepted;
        logic               take_cal_sample;
    } t_result;

    // Reported number of a one-hot mode; anything else reads as error.
    function automatic logic [3:0] mode_code(input t_mode m);
        logic [3:0] c;
        case (m)
            MODE_BOOT:      c = CODE_BOOT;
            MODE_SELF_TEST: c = CODE_SELF_TEST;
            MODE_IDLE:      c = CODE_IDLE;
            MODE_CAL:       c = CODE_CAL;
            MODE_READY:     c = CODE_READY;
            MODE_ARMED:     c = CODE_ARMED;
            MODE_SPINUP:    c = CODE_SPINUP;
            MODE_RUNNING:   c = CODE_RUNNING;
            MODE_CROSSING:  c = CODE_CROSSING;
            MODE_CURVE:     c = CODE_CURVE;
            MODE_LOST:      c = CODE_LOST;
            MODE_FINISH:    c = CODE_FINISH;
            MODE_SAFE_STOP: c = CODE_SAFE_STOP;
            MODE_HWTEST:    c = CODE_HWTEST;
            default:        c = CODE_ERROR;
        endcase
        return c;
    endfunction

endpackage

// ----- design/lfms_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfms_cfg
// Configuration register file: fan delay, minimum run time and base speed.
// ----------------------------------------------------------------------------
module lfms_cfg
    import lfms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken; an index past the list is dropped.
    assign o_cfg_ready = 1'b1;

    // Decode the write transaction into the addressed register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FAN_DELAY:    n_cfg.fan_delay_ms      = i_cfg_data[15:0];
                CFG_FINISH_MIN:   n_cfg.finish_min_run_ms = i_cfg_data;
                CFG_CRUISE_SPEED: n_cfg.cruise_speed      = i_cfg_data[11:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fan_delay_ms      <= FAN_DELAY_RESET;
            r_cfg.finish_min_run_ms <= FINISH_MIN_RESET;
            r_cfg.cruise_speed      <= CRUISE_SPEED_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/lfms_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfms_step
// Next-state and command logic for one transaction: request latching,
// stop and fault override, and one pass through the mode table.
// ----------------------------------------------------------------------------
module lfms_step
    import lfms_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  t_state  i_state,
    output t_state  o_state,
    output t_result o_result
);

    logic               w_is_tick;
    logic               w_stop_hit;
    t_mode              w_m0;
    t_mode              w_m1;
    logic [31:0]        w_e0;
    logic [31:0]        w_age;
    logic [31:0]        w_run_age;
    logic               w_safe;
    logic [3:0]         w_pend;
    logic [2:0]         w_fault;
    logic [10:0]        w_half;
    logic signed [11:0] w_pos;
    logic signed [11:0] w_neg;

    // Stop override happens before the table; it restarts the mode timer unless the mode is already safe stop.
    assign w_is_tick  = (i_item.opcode == OP_TICK);
    assign w_stop_hit = w_is_tick && (i_state.pending[REQ_STOP] || i_item.critical_fault);
    assign w_m0       = w_stop_hit ? MODE_SAFE_STOP : i_state.mode;
    assign w_e0       = (w_stop_hit && (i_state.mode != MODE_SAFE_STOP))
                        ? i_item.now_ms : i_state.enter_time;
    assign w_age      = i_item.now_ms - w_e0;
    assign w_run_age  = i_item.now_ms - i_state.run_start_time;

    // Spin search targets are plus and minus half the base speed.
    assign w_half = i_cfg.cruise_speed[11:1];
    assign w_pos  = signed'({1'b0, w_half});
    assign w_neg  = -w_pos;

    // Mode table and request handling.
    always_comb begin
        w_m1     = w_m0;
        w_safe   = 1'b0;
        w_pend   = i_state.pending;
        w_fault  = i_state.fault;
        o_result = '0;
        o_state  = i_state;

        case (i_item.opcode)
            OP_STOP:   w_pend[REQ_STOP]   = 1'b1;
            OP_ARM:    w_pend[REQ_ARM]    = 1'b1;
            OP_DISARM: w_pend[REQ_DISARM] = 1'b1;
            OP_START:  w_pend[REQ_START]  = 1'b1;
            OP_HWTEST: begin
                if ((i_state.mode == MODE_IDLE) || (i_state.mode == MODE_READY)) begin
                    w_m1              = MODE_HWTEST;
                    o_result.accepted = 1'b1;
                end
            end
            OP_CAL_BEGIN: w_m1 = MODE_CAL;
            OP_CAL_END: begin
                if (i_item.check_ok) begin
                    w_m1 = MODE_READY;
                end else begin
                    w_fault[FLT_SENSOR] = 1'b1;
                    w_m1                = MODE_ERROR;
                end
            end
            OP_TICK: begin
                if (w_stop_hit) begin
                    w_pend[REQ_STOP] = 1'b0;
                end
                case (w_m0)
                    MODE_BOOT: begin
                        w_safe = 1'b1;
                        w_m1   = MODE_SELF_TEST;
                    end
                    MODE_SELF_TEST: begin
                        if (!i_item.check_ok) begin
                            w_fault[FLT_CONFIG] = 1'b1;
                            w_m1                = MODE_ERROR;
                        end else begin
                            w_m1 = MODE_IDLE;
                        end
                    end
                    MODE_IDLE: begin
                        w_safe = 1'b1;
                        if (w_pend[REQ_ARM]) begin
                            w_pend[REQ_ARM] = 1'b0;
                            w_m1            = MODE_ARMED;
                        end
                    end
                    MODE_CAL: begin
                        o_result.take_cal_sample = 1'b1;
                        o_result.motor_cmd       = MOTOR_COAST;
                        o_result.fan_cmd         = FAN_OFF;
                    end
                    MODE_READY: begin
                        o_result.motor_cmd = MOTOR_COAST;
                        o_result.fan_cmd   = FAN_OFF;
                        if (w_pend[REQ_ARM]) begin
                            w_pend[REQ_ARM] = 1'b0;
                            w_m1            = MODE_ARMED;
                        end
                    end
                    MODE_ARMED: begin
                        o_result.motor_cmd = MOTOR_COAST;
                        if (w_pend[REQ_DISARM]) begin
                            w_pend[REQ_DISARM] = 1'b0;
                            w_m1               = MODE_READY;
                        end else if (w_pend[REQ_START] || i_item.right_marker) begin
                            w_pend[REQ_START] = 1'b0;
                            w_m1              = MODE_SPINUP;
                        end
                    end
                    MODE_SPINUP: begin
                        o_result.fan_cmd   = FAN_RAMP;
                        o_result.motor_cmd = MOTOR_COAST;
                        if (w_age >= {16'd0, i_cfg.fan_delay_ms}) begin
                            o_state.run_start_time = i_item.now_ms;
                            w_m1                   = MODE_RUNNING;
                        end
                    end
                    MODE_RUNNING: begin
                        o_result.fan_cmd = FAN_RUN;
                        if (i_item.crossing_seen) begin
                            w_m1 = MODE_CROSSING;
                        end else if (i_item.loss_confirmed) begin
                            w_m1 = MODE_LOST;
                        end else if (i_item.right_marker &&
                                     (w_run_age > i_cfg.finish_min_run_ms)) begin
                            w_m1 = MODE_FINISH;
                        end else if (i_item.left_curve) begin
                            w_m1 = MODE_CURVE;
                        end else begin
                            o_result.motor_cmd = MOTOR_PID;
                        end
                    end
                    MODE_CROSSING: begin
                        o_result.fan_cmd       = FAN_RUN;
                        o_result.motor_cmd     = MOTOR_PID;
                        o_result.hold_integral = 1'b1;
                        if (!i_item.crossing_seen) begin
                            w_m1 = MODE_RUNNING;
                        end
                    end
                    MODE_CURVE: begin
                        o_result.fan_cmd   = FAN_RUN;
                        o_result.motor_cmd = MOTOR_PID;
                        if (i_item.crossing_seen) begin
                            w_m1 = MODE_CROSSING;
                        end else if (i_item.loss_confirmed) begin
                            w_m1 = MODE_LOST;
                        end else if (w_age > CURVE_TIMEOUT_MS) begin
                            w_m1 = MODE_RUNNING;
                        end
                    end
                    MODE_LOST: begin
                        o_result.fan_cmd     = FAN_RUN;
                        o_result.motor_cmd   = MOTOR_SPIN;
                        o_result.left_drive  = i_item.error_negative ? w_neg : w_pos;
                        o_result.right_drive = i_item.error_negative ? w_pos : w_neg;
                        if (i_item.line_present && !i_item.line_missing) begin
                            w_m1 = MODE_RUNNING;
                        end else if (w_age > LOST_TIMEOUT_MS) begin
                            w_m1 = MODE_SAFE_STOP;
                        end
                    end
                    MODE_FINISH: begin
                        w_safe = 1'b1;
                        w_m1   = MODE_SAFE_STOP;
                    end
                    MODE_SAFE_STOP: begin
                        w_safe = 1'b1;
                        if (w_pend[REQ_DISARM]) begin
                            w_pend[REQ_DISARM] = 1'b0;
                            w_fault            = '0;
                            w_m1               = MODE_IDLE;
                        end
                    end
                    MODE_HWTEST: begin
                        if (w_age > HWTEST_TIMEOUT_MS) begin
                            w_fault[FLT_HWTO] = 1'b1;
                            w_m1              = MODE_SAFE_STOP;
                        end
                    end
                    default: w_safe = 1'b1;
                endcase
            end
            default: w_m1 = w_m0;
        endcase

        // Safe outputs override whatever the row chose.
        if (w_safe) begin
            o_result.motor_cmd = MOTOR_BRAKE;
            o_result.fan_cmd   = FAN_OFF;
            o_result.pid_clear = 1'b1;
        end

        o_result.mode       = mode_code(w_m1);
        o_result.fault_bits = w_fault;

        // The entry time reloads only on a real change of mode.
        o_state.mode       = w_m1;
        o_state.enter_time = (w_m1 != w_m0) ? i_item.now_ms : w_e0;
        o_state.pending    = w_pend;
        o_state.fault      = w_fault;
    end

endmodule

// ----- design/lfms_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfms_seq
// Input register, sequencer state and result register around the step logic.
// ----------------------------------------------------------------------------
module lfms_seq
    import lfms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_item   i_item,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    logic    r_in_valid;
    t_item   r_in;
    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_result r_res;
    t_result n_res;
    logic    w_fire;

    // The registered item is processed when the result slot is free or draining.
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    lfms_step u_step (
        .i_cfg    (i_cfg),
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_item;
        end
    end

    // Sequencer state advances once per processed transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode           <= MODE_BOOT;
            r_state.enter_time     <= '0;
            r_state.run_start_time <= '0;
            r_state.fault          <= '0;
            r_state.pending        <= '0;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;

    // State only moves when a transaction is processed.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_state))
        else $error("sequencer state changed without a transaction");

    // A processed transaction always leaves a result behind.
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed transaction produced no result");

    // Fault flags are cleared only by a tick.
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_in.opcode != OP_TICK)) |=>
        ((r_state.fault & $past(r_state.fault)) == $past(r_state.fault)))
        else $error("fault flag cleared by a request");

    // An accepted hardware test always reports the hardware test mode.
    a_accept_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.accepted) |-> (r_res.mode == CODE_HWTEST))
        else $error("hardware test accepted without entering the mode");

    // Drive targets are zero unless spin search is commanded.
    a_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.motor_cmd != MOTOR_SPIN)) |->
        ((r_res.left_drive == '0) && (r_res.right_drive == '0)))
        else $error("drive target set outside spin search");

endmodule

// ----- design/line_follower_mode_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_mode_sequencer
// Supervisory mode sequencer for a line-following robot. Each transaction is
// a control tick or a request and yields one motor, fan and PID command.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_ready     opcode, time, sensor flags
//  output    out        o_out_valid / i_out_ready   mode, commands, faults
//  config    in         i_cfg_valid / o_cfg_ready   register index, write data
//
//  One transaction per cycle is sustained while the output is not stalled; a result passes
//  through the input register, then the result register, before it is valid.
//  The mode table is one level of compare-and-select logic on the state.
//  Reset is synchronous and active low and returns the mode to boot.
//  A stalled output holds its result while the input register keeps one more
//  transaction; the input stalls only when both are occupied.
// ----------------------------------------------------------------------------
module line_follower_mode_sequencer
    import lfms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // Input channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_opcode,
    input  logic [31:0]        i_now_ms,
    input  logic               i_check_ok,
    input  logic               i_critical_fault,
    input  logic               i_crossing_seen,
    input  logic               i_loss_confirmed,
    input  logic               i_right_marker,
    input  logic               i_left_curve,
    input  logic               i_line_present,
    input  logic               i_line_missing,
    input  logic               i_error_negative,
    // Output channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_mode,
    output logic [2:0]         o_motor_cmd,
    output logic [1:0]         o_fan_cmd,
    output logic               o_pid_clear,
    output logic               o_hold_integral,
    output logic signed [11:0] o_left_drive,
    output logic signed [11:0] o_right_drive,
    output logic [2:0]         o_fault_bits,
    output logic               o_accepted,
    output logic               o_take_cal_sample
);

    t_cfg    w_cfg;
    t_item   w_item;
    t_result w_result;

    lfms_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Gather the input fields into one item.
    always_comb begin
        w_item.opcode         = t_opcode'(i_opcode);
        w_item.now_ms         = i_now_ms;
        w_item.check_ok       = i_check_ok;
        w_item.critical_fault = i_critical_fault;
        w_item.crossing_seen  = i_crossing_seen;
        w_item.loss_confirmed = i_loss_confirmed;
        w_item.right_marker   = i_right_marker;
        w_item.left_curve     = i_left_curve;
        w_item.line_present   = i_line_present;
        w_item.line_missing   = i_line_missing;
        w_item.error_negative = i_error_negative;
    end

    lfms_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (w_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    // Spread the result over the output ports.
    assign o_mode            = w_result.mode;
    assign o_motor_cmd       = w_result.motor_cmd;
    assign o_fan_cmd         = w_result.fan_cmd;
    assign o_pid_clear       = w_result.pid_clear;
    assign o_hold_integral   = w_result.hold_integral;
    assign o_left_drive      = w_result.left_drive;
    assign o_right_drive     = w_result.right_drive;
    assign o_fault_bits      = w_result.fault_bits;
    assign o_accepted        = w_result.accepted;
    assign o_take_cal_sample = w_result.take_cal_sample;

endmodule
